### rtl/min_tracking_stack_assert.svh
// ----------------------------------------------------------------------------
// min_tracking_stack assertion macros
// concurrent checks sampled on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("min_tracking_stack check failed");

// next-cycle implication
`define MTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("min_tracking_stack check failed");

`endif

### rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and constants of the min tracking stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FILL_W        = 7;
  localparam int unsigned DEFAULT_DEPTH = 64;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_UNDERFLOW = 2'd1,
    STS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

endpackage

### rtl/mts_stack_mem.sv
// ----------------------------------------------------------------------------
// mts_stack_mem
// single write port, single read port stack storage, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mts_stack_mem #(
  parameter int unsigned Depth = mts_pkg::DEFAULT_DEPTH,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AddrW-1:0]                  waddr_i,
  input  logic signed [mts_pkg::DATA_W-1:0] wdata_i,
  input  logic [AddrW-1:0]                  raddr_i,
  output logic signed [mts_pkg::DATA_W-1:0] rdata_o
);

  logic signed [mts_pkg::DATA_W-1:0] mem_q [Depth];
  logic signed [mts_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/min_tracking_stack.sv
// push, overflow and underflow give their word in the cycle after start;
// pop gives its word after the pop state: the new top and minimum come
// from the stack memories, whose read data are registered
// one push per cycle while not busy; a pop holds busy until its word is given
// reset (rst_ni low, async) empties both stacks; memory contents stay undefined
// the receiver cannot stall: done_o marks each result word for one cycle
// ----------------------------------------------------------------------------
// min_tracking_stack
// lifo of signed 32-bit words that tracks its running minimum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_tracking_stack #(
  parameter int unsigned StackDepth = mts_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type_i,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value_i,
  output logic                              done_o,
  output logic signed [mts_pkg::DATA_W-1:0] top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0] min_value_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o,
  output logic [mts_pkg::FILL_W-1:0]        fill_count_o
);

  // address bits index the memories, pointer bits also hold the full count
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned PtrW  = $clog2(StackDepth + 1);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  mts_pkg::state_e  state_q, state_d;
  logic [PtrW-1:0]  vptr_q, vptr_d;      // entries in the value stack
  logic [PtrW-1:0]  mptr_q, mptr_d;      // entries in the minimum stack
  logic signed [mts_pkg::DATA_W-1:0] top_q, top_d;  // cached top, 0 when empty
  logic signed [mts_pkg::DATA_W-1:0] min_q, min_d;  // cached minimum, INT_MAX when empty
  logic             pop_min_q, pop_min_d; // pop in flight also popped the minimum stack
  logic             done_q, done_d;
  mts_pkg::status_e status_q, status_d;

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  logic accept;
  logic is_push;
  logic stack_full;
  logic stack_empty;
  logic push_ok;
  logic min_push;
  logic pop_ok;
  logic pop_min;

  assign busy        = (state_q != mts_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign is_push     = (req_type_i == mts_pkg::REQ_PUSH);
  assign stack_full  = (vptr_q == PtrW'(StackDepth));
  assign stack_empty = (vptr_q == '0);

  // a push also goes onto the minimum stack when it does not exceed the minimum
  assign push_ok  = accept && is_push && !stack_full;
  assign min_push = push_ok && (push_value_i <= min_q) && (mptr_q != PtrW'(StackDepth));

  // a pop removes the cached top; the minimum stack follows when they match
  assign pop_ok  = accept && !is_push && !stack_empty;
  assign pop_min = pop_ok && (mptr_q != '0) && (top_q == min_q);

  // ---------------------------------------------------------------------------
  // memory ports
  // ---------------------------------------------------------------------------
  // the read always targets the entry just below the top, so a pop finds the
  // new top and the new minimum in the cycle after; reads and writes never meet
  // in the same request, and a write is in the array before the next read
  logic [PtrW-1:0] vrd_ptr;
  logic [PtrW-1:0] mrd_ptr;
  logic signed [mts_pkg::DATA_W-1:0] val_rdata;
  logic signed [mts_pkg::DATA_W-1:0] min_rdata;

  assign vrd_ptr = vptr_q - PtrW'(2);
  assign mrd_ptr = mptr_q - PtrW'(2);

  mts_stack_mem #(
    .Depth (StackDepth)
  ) u_value_mem (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (vptr_q[AddrW-1:0]),
    .wdata_i (push_value_i),
    .raddr_i (vrd_ptr[AddrW-1:0]),
    .rdata_o (val_rdata)
  );

  mts_stack_mem #(
    .Depth (StackDepth)
  ) u_minimum_mem (
    .clk_i   (clk_i),
    .we_i    (min_push),
    .waddr_i (mptr_q[AddrW-1:0]),
    .wdata_i (push_value_i),
    .raddr_i (mrd_ptr[AddrW-1:0]),
    .rdata_o (min_rdata)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      mts_pkg::ST_IDLE: begin
        if (pop_ok) begin
          state_d = mts_pkg::ST_POP;
        end
      end
      mts_pkg::ST_POP: begin
        state_d = mts_pkg::ST_IDLE;
      end
      default: begin
        state_d = mts_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    vptr_d    = vptr_q;
    mptr_d    = mptr_q;
    top_d     = top_q;
    min_d     = min_q;
    pop_min_d = pop_min_q;
    done_d    = 1'b0;
    status_d  = status_q;
    case (state_q)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          // pops that really remove a word finish in the next state
          done_d   = !pop_ok;
          status_d = mts_pkg::STS_OK;
          if (is_push && stack_full) begin
            status_d = mts_pkg::STS_OVERFLOW;
          end
          if (!is_push && stack_empty) begin
            status_d = mts_pkg::STS_UNDERFLOW;
          end
        end
        if (push_ok) begin
          vptr_d = vptr_q + PtrW'(1);
          top_d  = push_value_i;
        end
        if (min_push) begin
          mptr_d = mptr_q + PtrW'(1);
          min_d  = push_value_i;
        end
        if (pop_ok) begin
          vptr_d    = vptr_q - PtrW'(1);
          pop_min_d = pop_min;
          if (pop_min) begin
            mptr_d = mptr_q - PtrW'(1);
          end
        end
      end
      mts_pkg::ST_POP: begin
        // pointers already moved, memory data is the entry below the old top
        done_d = 1'b1;
        top_d  = (vptr_q == '0) ? '0 : val_rdata;
        if (pop_min_q) begin
          min_d = (mptr_q == '0) ? mts_pkg::INT_MAX : min_rdata;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mts_pkg::ST_IDLE;
      vptr_q    <= '0;
      mptr_q    <= '0;
      top_q     <= '0;
      min_q     <= mts_pkg::INT_MAX;
      pop_min_q <= 1'b0;
      done_q    <= 1'b0;
      status_q  <= mts_pkg::STS_OK;
    end else begin
      state_q   <= state_d;
      vptr_q    <= vptr_d;
      mptr_q    <= mptr_d;
      top_q     <= top_d;
      min_q     <= min_d;
      pop_min_q <= pop_min_d;
      done_q    <= done_d;
      status_q  <= status_d;
    end
  end

  // ---------------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------------
  // fill count is the pointer fitted to the fixed count width
  logic [mts_pkg::FILL_W+PtrW-1:0] fill_ext;

  assign fill_ext     = {{mts_pkg::FILL_W{1'b0}}, vptr_q};
  assign fill_count_o = fill_ext[mts_pkg::FILL_W-1:0];
  assign done_o       = done_q;
  assign top_value_o  = top_q;
  assign min_value_o  = min_q;
  assign is_empty_o   = (vptr_q == '0);
  assign status_o     = status_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "min_tracking_stack_assert.svh"

  `MTS_ASSERT_IMP(a_min_not_deeper, 1'b1, mptr_q <= vptr_q)
  `MTS_ASSERT_NXT(a_pop_finishes, state_q == mts_pkg::ST_POP, done_q && !busy)
  `MTS_ASSERT_NXT(a_push_one_cycle, accept && is_push, done_q)
  `MTS_ASSERT_IMP(a_empty_min, (mptr_q == '0) && !busy, min_q == mts_pkg::INT_MAX)

endmodule
